// ----- src/cob_pkg.sv -----
// ----------------------------------------------------------------------------
// cob_pkg
// Types, codes and helper functions shared by the cursor overlay blend unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cob_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned OFS_W      = 18;

  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
  localparam logic [15:0] ROUND_BIAS   = 16'd127;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FORMAT_MODE = 3'd0,
    CFG_ORIGIN_X    = 3'd1,
    CFG_ORIGIN_Y    = 3'd2,
    CFG_AREA_X      = 3'd3,
    CFG_AREA_Y      = 3'd4,
    CFG_WIDTH       = 3'd5,
    CFG_HEIGHT      = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    FMT_24_R2G1B0 = 3'd0,
    FMT_24_R0G1B2 = 3'd1,
    FMT_32_R2G1B0 = 3'd2,
    FMT_32_R0G1B2 = 3'd3,
    FMT_32_R3G2B1 = 3'd4,
    FMT_32_R1G2B3 = 3'd5,
    FMT_PASS      = 3'd6
  } fmt_e;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_e;

  typedef struct packed {
    logic        cmd;
    logic [11:0] cursor_index;
    logic [31:0] cursor_word;
    logic [31:0] frame_pixel;
    logic [13:0] pixel_column;
    logic [13:0] pixel_row;
  } in_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    logic        covered;
  } out_t;

  // configuration as seen by the datapath, cursor corner already in area coordinates
  typedef struct packed {
    logic [2:0]       fmt;
    logic [OFS_W-1:0] cx;
    logic [OFS_W-1:0] cy;
    logic [6:0]       width;
    logic [6:0]       height;
  } cfg_t;

  function automatic logic [1:0] red_pos(input logic [2:0] fmt);
    logic [1:0] pos;
    case (fmt)
      FMT_24_R2G1B0: pos = 2'd2;
      FMT_24_R0G1B2: pos = 2'd0;
      FMT_32_R2G1B0: pos = 2'd2;
      FMT_32_R0G1B2: pos = 2'd0;
      FMT_32_R3G2B1: pos = 2'd3;
      FMT_32_R1G2B3: pos = 2'd1;
      default:       pos = 2'd0;
    endcase
    return pos;
  endfunction

  function automatic logic [1:0] green_pos(input logic [2:0] fmt);
    logic [1:0] pos;
    case (fmt)
      FMT_32_R3G2B1: pos = 2'd2;
      FMT_32_R1G2B3: pos = 2'd2;
      default:       pos = 2'd1;
    endcase
    return pos;
  endfunction

  function automatic logic [1:0] blue_pos(input logic [2:0] fmt);
    logic [1:0] pos;
    case (fmt)
      FMT_24_R2G1B0: pos = 2'd0;
      FMT_24_R0G1B2: pos = 2'd2;
      FMT_32_R2G1B0: pos = 2'd0;
      FMT_32_R0G1B2: pos = 2'd2;
      FMT_32_R3G2B1: pos = 2'd1;
      FMT_32_R1G2B3: pos = 2'd3;
      default:       pos = 2'd0;
    endcase
    return pos;
  endfunction

endpackage

`default_nettype wire

// ----- src/cob_stream_if.sv -----
// ----------------------------------------------------------------------------
// cob_stream_if
// Valid/ready stream channel carrying one payload struct per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface cob_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/cob_cfg.sv -----
// ----------------------------------------------------------------------------
// cob_cfg
// Configuration registers and the derived cursor corner in area coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

module cob_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [cob_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [cob_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output      cob_pkg::cfg_t                   cfg_o
);

  logic [2:0]                   fmt_q;
  logic [15:0]                  origin_x_q;
  logic [15:0]                  origin_y_q;
  logic [14:0]                  area_x_q;
  logic [14:0]                  area_y_q;
  logic [6:0]                   width_q;
  logic [6:0]                   height_q;
  logic [cob_pkg::OFS_W-1:0]    cx_q, cx_d;
  logic [cob_pkg::OFS_W-1:0]    cy_q, cy_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q      <= cob_pkg::FMT_PASS;
      origin_x_q <= '0;
      origin_y_q <= '0;
      area_x_q   <= '0;
      area_y_q   <= '0;
      width_q    <= '0;
      height_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cob_pkg::CFG_FORMAT_MODE: fmt_q      <= cfg_wdata_i[2:0];
        cob_pkg::CFG_ORIGIN_X:    origin_x_q <= cfg_wdata_i[15:0];
        cob_pkg::CFG_ORIGIN_Y:    origin_y_q <= cfg_wdata_i[15:0];
        cob_pkg::CFG_AREA_X:      area_x_q   <= cfg_wdata_i[14:0];
        cob_pkg::CFG_AREA_Y:      area_y_q   <= cfg_wdata_i[14:0];
        cob_pkg::CFG_WIDTH:       width_q    <= cfg_wdata_i[6:0];
        cob_pkg::CFG_HEIGHT:      height_q   <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  // cursor corner = sign-extended origin minus area edge
  assign cx_d = {{2{origin_x_q[15]}}, origin_x_q} - {3'b000, area_x_q};
  assign cy_d = {{2{origin_y_q[15]}}, origin_y_q} - {3'b000, area_y_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
    end else begin
      cx_q <= cx_d;
      cy_q <= cy_d;
    end
  end

  assign cfg_o.fmt    = fmt_q;
  assign cfg_o.cx     = cx_q;
  assign cfg_o.cy     = cy_q;
  assign cfg_o.width  = width_q;
  assign cfg_o.height = height_q;

endmodule

`default_nettype wire

// ----- src/cob_store.sv -----
// ----------------------------------------------------------------------------
// cob_store
// Cursor image memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cob_store #(
  parameter int unsigned Depth = 4096,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [31:0]      wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output      logic [31:0]      rdata_o
);

  logic [31:0] mem [Depth];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/cob_blend.sv -----
// ----------------------------------------------------------------------------
// cob_blend
// Premultiplied alpha blend of one cursor word onto the red, green and blue
// bytes of an image pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module cob_blend (
  input  wire logic [31:0] pixel_i,
  input  wire logic [31:0] word_i,
  input  wire logic [2:0]  fmt_i,
  input  wire logic        hit_i,
  output      logic [31:0] pixel_o
);

  logic [1:0]  pos [3];
  logic [7:0]  src [3];
  logic [7:0]  dst [3];
  logic [15:0] prod [3];
  logic [16:0] acc [3];
  logic [7:0]  res [3];
  logic [7:0]  alpha;
  logic [7:0]  inv_alpha;

  assign alpha     = word_i[31:24];
  assign inv_alpha = cob_pkg::ALPHA_OPAQUE - alpha;

  assign pos[0] = cob_pkg::red_pos(fmt_i);
  assign pos[1] = cob_pkg::green_pos(fmt_i);
  assign pos[2] = cob_pkg::blue_pos(fmt_i);
  assign src[0] = word_i[23:16];
  assign src[1] = word_i[15:8];
  assign src[2] = word_i[7:0];

  // x/255 for 16-bit x as (x + (x >> 8) + 1) >> 8
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dst[c]  = pixel_i[{pos[c], 3'b000} +: 8];
      prod[c] = 16'(dst[c]) * 16'(inv_alpha) + cob_pkg::ROUND_BIAS;
      acc[c]  = 17'(prod[c]) + 17'(prod[c][15:8]) + 17'd1;
      if (alpha == cob_pkg::ALPHA_OPAQUE) begin
        res[c] = src[c];
      end else begin
        res[c] = acc[c][15:8] + src[c];
      end
    end
  end

  always_comb begin
    pixel_o = pixel_i;
    if (hit_i) begin
      for (int b = 0; b < 4; b++) begin
        if (pos[0] == 2'(b)) begin
          pixel_o[8*b +: 8] = res[0];
        end else if (pos[1] == 2'(b)) begin
          pixel_o[8*b +: 8] = res[1];
        end else if (pos[2] == 2'(b)) begin
          pixel_o[8*b +: 8] = res[2];
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/cursor_overlay_blend_unit.sv -----
// ----------------------------------------------------------------------------
// cursor_overlay_blend_unit
// Hardware cursor overlay with premultiplied alpha blend on a pixel stream.
// ----------------------------------------------------------------------------
// Takes one request per clock while no pixel in the input stage is stalled.
// A load request writes a cursor word into the CursorSide x CursorSide store
// and retires in the input stage with no result. A pixel request passes the
// input stage (position test and store read address), the store read stage
// (the memory's registered read port) and the output register after the
// blend. The single write and single read port of the store let a load and
// a pixel follow each other on consecutive cycles; the store has no reset,
// so only loaded cursor entries may be covered by pixels.
`default_nettype none

module cursor_overlay_blend_unit #(
  parameter int unsigned CursorSide = 64
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [cob_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [cob_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  cob_stream_if.sink                           in_i,
  cob_stream_if.source                         out_o
);

  localparam int unsigned Depth = CursorSide * CursorSide;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned SideW = $clog2(CursorSide);
  localparam int unsigned IdxW  = ((AddrW > 12) ? AddrW : 12) + 1;
  localparam int unsigned PosW  = cob_pkg::OFS_W + 1;

  cob_pkg::cfg_t cfg;

  logic          s1_v_q, s1_v_d;
  cob_pkg::in_t  s1_q;
  logic          s2_v_q, s2_v_d;
  logic [31:0]   s2_pix_q;
  logic          s2_hit_q;
  logic [2:0]    s2_fmt_q;
  logic          out_v_q, out_v_d;
  cob_pkg::out_t out_q;

  logic             accept;
  logic             s1_load;
  logic             s1_leave;
  logic             s2_free;
  logic             s2_move;
  logic             out_free;
  logic             st_we;
  logic             st_re;
  logic [IdxW-1:0]  idx_ext;
  logic [AddrW-1:0] raddr;
  logic [PosW-1:0]  pos_i;
  logic [PosW-1:0]  pos_j;
  logic             hit;
  logic [31:0]      word;
  logic [31:0]      blended;

  cob_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // flow control
  assign s1_load  = (s1_q.cmd == cob_pkg::CMD_LOAD);
  assign out_free = !out_v_q || out_o.ready;
  assign s2_free  = !s2_v_q || out_free;
  assign s2_move  = s2_v_q && out_free;
  assign s1_leave = s1_v_q && (s1_load || s2_free);
  assign in_i.ready = !s1_v_q || s1_load || s2_free;
  assign accept   = in_i.valid && in_i.ready;

  assign s1_v_d = accept ? 1'b1 : (s1_leave ? 1'b0 : s1_v_q);
  assign st_re  = s1_v_q && !s1_load && s2_free;
  assign s2_v_d = st_re ? 1'b1 : (s2_move ? 1'b0 : s2_v_q);
  assign out_v_d = s2_move ? 1'b1 : (out_o.ready ? 1'b0 : out_v_q);

  // position of the pixel relative to the cursor corner
  assign pos_i = PosW'(s1_q.pixel_column) - {cfg.cx[cob_pkg::OFS_W-1], cfg.cx};
  assign pos_j = PosW'(s1_q.pixel_row) - {cfg.cy[cob_pkg::OFS_W-1], cfg.cy};

  assign hit = (cfg.fmt < cob_pkg::FMT_PASS)
            && !pos_i[PosW-1] && !pos_j[PosW-1]
            && (pos_i[PosW-2:0] < (PosW-1)'(cfg.width))
            && (pos_j[PosW-2:0] < (PosW-1)'(cfg.height))
            && (pos_i[PosW-2:0] < (PosW-1)'(CursorSide))
            && (pos_j[PosW-2:0] < (PosW-1)'(CursorSide));

  assign raddr = AddrW'(AddrW'(pos_j[SideW-1:0]) * AddrW'(CursorSide))
               + AddrW'(pos_i[SideW-1:0]);

  assign idx_ext = IdxW'(s1_q.cursor_index);
  assign st_we   = s1_v_q && s1_load && (idx_ext < IdxW'(Depth));

  cob_store #(
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (idx_ext[AddrW-1:0]),
    .wdata_i (s1_q.cursor_word),
    .re_i    (st_re),
    .raddr_i (raddr),
    .rdata_o (word)
  );

  cob_blend u_blend (
    .pixel_i (s2_pix_q),
    .word_i  (word),
    .fmt_i   (s2_fmt_q),
    .hit_i   (s2_hit_q),
    .pixel_o (blended)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      s2_v_q  <= s2_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= in_i.data;
    end
    if (st_re) begin
      s2_pix_q <= s1_q.frame_pixel;
      s2_hit_q <= hit;
      s2_fmt_q <= cfg.fmt;
    end
    if (s2_move) begin
      out_q.pixel_out <= blended;
      out_q.covered   <= s2_hit_q;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cursor overlay blend unit. Cursor words are
// loaded into the store, then pixel requests are streamed through every
// format mode and a range of cursor placements and sizes. A predictor
// tracks the cursor store and registers and checks each blended pixel,
// with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module tb;

  localparam int LIMIT = 200000;
  localparam int SIDE  = 64;

  class overlay_checker;
    logic [31:0]        cursor_image [SIDE*SIDE];
    bit                 loaded       [SIDE*SIDE];
    logic [2:0]         fmt   = cob_pkg::FMT_PASS;
    logic signed [15:0] org_x = '0;
    logic signed [15:0] org_y = '0;
    logic [14:0]        ar_x  = '0;
    logic [14:0]        ar_y  = '0;
    logic [6:0]         cur_w = '0;
    logic [6:0]         cur_h = '0;
    int                 red_lane   [6] = '{2, 0, 2, 0, 3, 1};
    int                 green_lane [6] = '{1, 1, 1, 1, 2, 2};
    int                 blue_lane  [6] = '{0, 2, 0, 2, 1, 3};
    cob_pkg::out_t      expected_pixels [$];
    int                 mismatches = 0;

    function void set_reg(cob_pkg::cfg_idx_e idx, logic [15:0] v);
      case (idx)
        cob_pkg::CFG_FORMAT_MODE: fmt = v[2:0];
        cob_pkg::CFG_ORIGIN_X:    org_x = v;
        cob_pkg::CFG_ORIGIN_Y:    org_y = v;
        cob_pkg::CFG_AREA_X:      ar_x = v[14:0];
        cob_pkg::CFG_AREA_Y:      ar_y = v[14:0];
        cob_pkg::CFG_WIDTH:       cur_w = v[6:0];
        cob_pkg::CFG_HEIGHT:      cur_h = v[6:0];
        default: ;
      endcase
    endfunction

    function int corner_x();
      return int'(org_x) - int'(ar_x);
    endfunction

    function int corner_y();
      return int'(org_y) - int'(ar_y);
    endfunction

    function int eff_w();
      return (cur_w > SIDE) ? SIDE : int'(cur_w);
    endfunction

    function int eff_h();
      return (cur_h > SIDE) ? SIDE : int'(cur_h);
    endfunction

    function bit covers(int col, int row, output int idx);
      int i;
      int j;
      i = col - corner_x();
      j = row - corner_y();
      idx = 0;
      if (fmt >= cob_pkg::FMT_PASS || i < 0 || j < 0 ||
          i >= eff_w() || j >= eff_h()) return 1'b0;
      idx = j * SIDE + i;
      return 1'b1;
    endfunction

    function logic [31:0] mix_lane(logic [31:0] pix, int lane, logic [7:0] src,
                                   logic [7:0] a);
      int dst;
      logic [7:0] res;
      dst = int'(pix[lane*8 +: 8]);
      if (a == 8'hFF) res = src;
      else res = 8'(((dst * (255 - int'(a)) + 127) / 255) + int'(src));
      pix[lane*8 +: 8] = res;
      return pix;
    endfunction

    function cob_pkg::out_t predict_pixel(cob_pkg::in_t req);
      cob_pkg::out_t r;
      int idx;
      logic [31:0] w;
      r.pixel_out = req.frame_pixel;
      r.covered   = covers(int'(req.pixel_column), int'(req.pixel_row), idx);
      if (r.covered) begin
        w = cursor_image[idx];
        r.pixel_out = mix_lane(r.pixel_out, red_lane[fmt], w[23:16], w[31:24]);
        r.pixel_out = mix_lane(r.pixel_out, green_lane[fmt], w[15:8], w[31:24]);
        r.pixel_out = mix_lane(r.pixel_out, blue_lane[fmt], w[7:0], w[31:24]);
      end
      return r;
    endfunction

    function void note_request(cob_pkg::in_t req);
      if (req.cmd == cob_pkg::CMD_LOAD) begin
        cursor_image[req.cursor_index] = req.cursor_word;
        loaded[req.cursor_index] = 1'b1;
      end else begin
        expected_pixels.push_back(predict_pixel(req));
      end
    endfunction

    function void check_pixel(cob_pkg::out_t got);
      cob_pkg::out_t want;
      if (expected_pixels.size() == 0) begin
        $error("unexpected result pixel_out=%08h covered=%0d", got.pixel_out, got.covered);
        mismatches++;
        return;
      end
      want = expected_pixels.pop_front();
      if (got.pixel_out !== want.pixel_out) begin
        $error("pixel_out expected %08h actual %08h", want.pixel_out, got.pixel_out);
        mismatches++;
      end
      if (got.covered !== want.covered) begin
        $error("covered expected %0d actual %0d", want.covered, got.covered);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we;
  logic [cob_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [cob_pkg::CFG_DATA_W-1:0] cfg_wdata;
  bit                             steady;
  int                             cycles;
  overlay_checker                 ovl = new();

  cob_stream_if #(.T(cob_pkg::in_t))  req_if ();
  cob_stream_if #(.T(cob_pkg::out_t)) res_if ();

  cursor_overlay_blend_unit #(.CursorSide(SIDE)) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (req_if),
    .out_o       (res_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    res_if.ready <= steady || ($urandom_range(0, 99) >= 38);
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) ovl.check_pixel(res_if.data);
  end

  function automatic logic [31:0] cursor_pattern();
    logic [7:0] a;
    case ($urandom_range(0, 4))
      0: a = 8'hFF;
      1: a = 8'h00;
      default: a = 8'($urandom);
    endcase
    return {a, 24'($urandom)};
  endfunction

  function automatic logic [31:0] pick_pixel();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic cob_pkg::in_t make_load(int idx, logic [31:0] word);
    cob_pkg::in_t r;
    r.cmd          = cob_pkg::CMD_LOAD;
    r.cursor_index = 12'(idx);
    r.cursor_word  = word;
    r.frame_pixel  = $urandom;
    r.pixel_column = 14'($urandom);
    r.pixel_row    = 14'($urandom);
    return r;
  endfunction

  function automatic cob_pkg::in_t make_pixel(int col, int row, logic [31:0] pix);
    cob_pkg::in_t r;
    r.cmd          = cob_pkg::CMD_PIXEL;
    r.cursor_index = 12'($urandom);
    r.cursor_word  = $urandom;
    r.frame_pixel  = pix;
    r.pixel_column = 14'(col);
    r.pixel_row    = 14'(row);
    return r;
  endfunction

  task automatic push_request(cob_pkg::in_t r);
    while (!steady && $urandom_range(0, 99) < 38) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    ovl.note_request(r);
  endtask

  // a covered entry that was never loaded gets a load first
  task automatic send_pixel(int col, int row, logic [31:0] pix);
    int idx;
    if (ovl.covers(col, row, idx) && !ovl.loaded[idx])
      push_request(make_load(idx, cursor_pattern()));
    push_request(make_pixel(col, row, pix));
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (ovl.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(cob_pkg::cfg_idx_e idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    ovl.set_reg(idx, val);
  endtask

  task automatic apply_settings(logic [2:0] fm, int ox, int oy, int ax, int ay,
                                int w, int h);
    write_reg(cob_pkg::CFG_FORMAT_MODE, {13'($urandom), fm});
    write_reg(cob_pkg::CFG_ORIGIN_X, 16'(ox));
    write_reg(cob_pkg::CFG_ORIGIN_Y, 16'(oy));
    write_reg(cob_pkg::CFG_AREA_X, {1'($urandom), 15'(ax)});
    write_reg(cob_pkg::CFG_AREA_Y, {1'($urandom), 15'(ay)});
    write_reg(cob_pkg::CFG_WIDTH, {9'($urandom), 7'(w)});
    write_reg(cob_pkg::CFG_HEIGHT, {9'($urandom), 7'(h)});
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic setup_phase(int p);
    int sizes_w [12] = '{64, 1, 127, 37, 0, 65, 64, 8, 20, 64, 64, 3};
    int sizes_h [12] = '{64, 127, 1, 40, 19, 64, 65, 0, 64, 2, 64, 64};
    int cx_t;
    int cy_t;
    int ax;
    int ay;
    int ox;
    int oy;
    if (p == 10) begin
      ox = -32768; ax = 32767; oy = 32767; ay = 0;
    end else if (p == 11) begin
      ox = 32767; ax = 0; oy = -32768; ay = 32767;
    end else begin
      cx_t = int'($urandom_range(0, 16460)) - 70;
      cy_t = int'($urandom_range(0, 16460)) - 70;
      ax = (cx_t >= 0) ? int'($urandom_range(0, 32767 - cx_t)) : int'($urandom_range(0, 32767));
      ay = (cy_t >= 0) ? int'($urandom_range(0, 32767 - cy_t)) : int'($urandom_range(0, 32767));
      ox = cx_t + ax;
      oy = cy_t + ay;
    end
    apply_settings(3'(p % 8), ox, oy, ax, ay, sizes_w[p], sizes_h[p]);
  endtask

  task automatic run_random(int n);
    int r;
    int col;
    int row;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        push_request(make_load($urandom_range(0, SIDE*SIDE-1), cursor_pattern()));
      end else if (r < 85) begin
        // mostly around and inside the cursor rectangle
        col = ovl.corner_x() + int'($urandom_range(0, ovl.eff_w() + 3)) - 2;
        row = ovl.corner_y() + int'($urandom_range(0, ovl.eff_h() + 3)) - 2;
        if (col < 0 || col > 16383) col = $urandom_range(0, 16383);
        if (row < 0 || row > 16383) row = $urandom_range(0, 16383);
        send_pixel(col, row, pick_pixel());
      end else begin
        send_pixel($urandom_range(0, 16383), $urandom_range(0, 16383), pick_pixel());
      end
    end
  endtask

  initial begin
    rst_ni       <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= cob_pkg::CFG_FORMAT_MODE;
    cfg_wdata    <= '0;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    steady = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: pass-through format, zero cursor size
    send_pixel(0, 0, 32'hDEAD_BEEF);
    send_pixel(16383, 16383, 32'hFFFF_FFFF);
    drain();

    apply_settings(cob_pkg::FMT_32_R3G2B1, 7, 3, 7, 3, 2, 2);
    push_request(make_load(0, 32'hFF12_3456));
    push_request(make_load(1, 32'h00FF_FFFF));
    push_request(make_load(SIDE, 32'h8080_4020));
    push_request(make_load(SIDE + 1, 32'hFE01_0203));
    push_request(make_load(SIDE*SIDE - 1, 32'hFFFF_FFFF));
    send_pixel(0, 0, 32'hFFFF_FFFF);
    send_pixel(1, 0, 32'hFFFF_FFFF);
    send_pixel(0, 1, 32'h0000_0000);
    send_pixel(1, 1, 32'hA5A5_A5A5);
    send_pixel(2, 0, 32'h1234_5678);
    send_pixel(0, 2, 32'h8765_4321);
    send_pixel(16383, 0, 32'h0000_0000);
    send_pixel(0, 16383, 32'hFFFF_FFFF);

    for (int p = 0; p < 12; p++) begin
      drain();
      setup_phase(p);
      steady = (p == 3);
      run_random(90);
    end
    steady = 1'b0;

    drain();
    repeat (10) @(posedge clk_i);
    if (ovl.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
